>>> hw/rtl/ptt_pkg.sv
package ptt_pkg;

  // Table size and derived widths
  localparam int TIMER_SLOTS = 16;
  localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int Q_DEPTH     = 2;
  localparam int Q_AW        = 1;
  localparam int Q_CW        = 2;

  // Request modes
  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_ADD    = 3'd1;
  localparam logic [2:0] MODE_PAUSE  = 3'd2;
  localparam logic [2:0] MODE_CANCEL = 3'd3;
  localparam logic [2:0] MODE_CHPER  = 3'd4;

  // Result kinds
  localparam logic [2:0] K_FIRED    = 3'd0;
  localparam logic [2:0] K_NOFIRE   = 3'd1;
  localparam logic [2:0] K_DONE     = 3'd2;
  localparam logic [2:0] K_NOTFOUND = 3'd3;
  localparam logic [2:0] K_FULL     = 3'd4;
  localparam logic [2:0] K_IGNORED  = 3'd5;

  // Slot states
  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_WORK  = 2'd1;
  localparam logic [1:0] ST_PAUSE = 2'd2;
  localparam logic [1:0] ST_DYING = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] timer_id;
    logic [31:0] period;
    logic        one_shot;
    logic        run_in_thread;
  } req_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] fired_id;
    logic        fired_in_thread;
    logic        last;
  } rsp_word_t;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_ADD,
    OP_PAUSE,
    OP_CANCEL,
    OP_CHPER,
    OP_IGNORE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] timer_id;
    logic [31:0] period;
    logic        one_shot;
    logic        thread;
  } cmd_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] period;
    logic [31:0] count;
    logic        one_shot;
    logic        thread;
  } entry_t;

endpackage

>>> hw/rtl/ptt_ram.sv
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
  input  logic [WIDTH-1:0]                              wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
  output logic [WIDTH-1:0]                              rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/ptt_front.sv
module ptt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  ptt_pkg::req_word_t  req,
  output logic                q_valid,
  output ptt_pkg::cmd_t       q_cmd,
  input  logic                q_pop
);

  ptt_pkg::cmd_t              q [ptt_pkg::Q_DEPTH];
  logic [ptt_pkg::Q_AW-1:0]   wp;
  logic [ptt_pkg::Q_AW-1:0]   rp;
  logic [ptt_pkg::Q_CW-1:0]   fill;
  ptt_pkg::cmd_t              cls;
  logic                       push;

  // Classify the incoming word
  always_comb begin
    cls.timer_id = req.timer_id;
    cls.period   = req.period;
    cls.one_shot = req.one_shot;
    cls.thread   = req.run_in_thread;
    case (req.mode)
      ptt_pkg::MODE_TICK:   cls.op = ptt_pkg::OP_TICK;
      ptt_pkg::MODE_ADD:    cls.op = ptt_pkg::OP_ADD;
      ptt_pkg::MODE_PAUSE:  cls.op = ptt_pkg::OP_PAUSE;
      ptt_pkg::MODE_CANCEL: cls.op = ptt_pkg::OP_CANCEL;
      ptt_pkg::MODE_CHPER:  cls.op = ptt_pkg::OP_CHPER;
      default:              cls.op = ptt_pkg::OP_IGNORE;
    endcase
    if (req.mode != ptt_pkg::MODE_TICK && req.timer_id == 16'd0) begin
      cls.op = ptt_pkg::OP_IGNORE;
    end
  end

  assign req_stall = (fill == ptt_pkg::Q_CW'(ptt_pkg::Q_DEPTH));
  assign push      = req_valid && !req_stall;
  assign q_valid   = (fill != '0);
  assign q_cmd     = q[rp];

  // Hold classified commands until the back end takes them
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        q[wp] <= cls;
        wp    <= wp + 1'b1;
      end
      if (q_pop) begin
        rp <= rp + 1'b1;
      end
      fill <= fill + ptt_pkg::Q_CW'(push) - ptt_pkg::Q_CW'(q_pop);
    end
  end

endmodule

>>> hw/rtl/ptt_back.sv
module ptt_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  ptt_pkg::cmd_t       q_cmd,
  output logic                q_pop,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output ptt_pkg::rsp_word_t  rsp
);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_RSP, S_RD, S_EVAL, S_DIV, S_UPD, S_ACT, S_END
  } state_t;

  localparam int EW = $bits(ptt_pkg::entry_t);

  state_t                     state;
  ptt_pkg::cmd_t              cmd;
  logic [ptt_pkg::SLOT_W-1:0] idx;
  ptt_pkg::entry_t            ent;
  logic [31:0]                rem;
  logic [31:0]                dsh;
  logic [4:0]                 dcnt;
  logic                       fire;
  logic                       pend_valid;
  ptt_pkg::rsp_word_t         pend;
  logic [1:0]                 slot_st [ptt_pkg::TIMER_SLOTS];

  logic [EW-1:0]              rd_raw;
  ptt_pkg::entry_t            e;
  logic                       wr_en;
  logic [ptt_pkg::SLOT_W-1:0] wr_addr;
  ptt_pkg::entry_t            wr_data;
  logic                       free_found;
  logic [ptt_pkg::SLOT_W-1:0] free_idx;
  logic [31:0]                peff_e;
  logic [31:0]                peff_r;
  logic [32:0]                r2;
  logic [31:0]                rem_next;
  logic                       out_free;
  logic                       out_load;
  ptt_pkg::rsp_word_t         out_next;
  logic                       upd_ok;
  logic                       last_slot;
  logic                       hit;

  ptt_ram #(
    .WIDTH (EW),
    .DEPTH (ptt_pkg::TIMER_SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (idx),
    .rd_data (rd_raw)
  );

  assign e         = ptt_pkg::entry_t'(rd_raw);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign last_slot = (idx == ptt_pkg::SLOT_W'(ptt_pkg::TIMER_SLOTS - 1));
  assign peff_e    = (e.period == 32'd0) ? 32'd1 : e.period;
  assign peff_r    = (ent.period == 32'd0) ? 32'd1 : ent.period;
  assign hit       = (slot_st[idx] != ptt_pkg::ST_FREE) && (e.id == cmd.timer_id);
  assign upd_ok    = !fire || !pend_valid || out_free;
  assign q_pop     = (state == S_IDLE) && q_valid;

  // Find the lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ptt_pkg::TIMER_SLOTS - 1; i >= 0; i--) begin
      if (slot_st[i] == ptt_pkg::ST_FREE) begin
        free_found = 1'b1;
        free_idx   = ptt_pkg::SLOT_W'(i);
      end
    end
  end

  // One step of the serial remainder
  always_comb begin
    r2 = {rem, dsh[31]};
    if (r2 >= {1'b0, peff_r}) begin
      rem_next = 32'(r2 - {1'b0, peff_r});
    end else begin
      rem_next = r2[31:0];
    end
  end

  // Drive table writes and the next result word
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = idx;
    wr_data  = ent;
    out_load = 1'b0;
    out_next = '{kind: ptt_pkg::K_DONE, fired_id: cmd.timer_id,
                 fired_in_thread: 1'b0, last: 1'b1};
    case (state)
      S_ADD: begin
        if (out_free) begin
          out_load = 1'b1;
          if (free_found) begin
            wr_en   = 1'b1;
            wr_addr = free_idx;
            wr_data = '{id: cmd.timer_id, period: cmd.period, count: 32'd0,
                        one_shot: cmd.one_shot, thread: cmd.thread};
          end else begin
            out_next.kind = ptt_pkg::K_FULL;
          end
        end
      end
      S_RSP: begin
        out_load      = out_free;
        out_next.kind = ptt_pkg::K_IGNORED;
      end
      S_UPD: begin
        wr_en         = 1'b1;
        wr_data.count = fire ? 32'd1 : ent.count + 32'd1;
        if (fire && pend_valid && out_free) begin
          out_load = 1'b1;
          out_next = pend;
        end
      end
      S_ACT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (cmd.op == ptt_pkg::OP_CHPER) begin
            wr_en          = 1'b1;
            wr_data.period = cmd.period;
          end
        end
      end
      S_END: begin
        out_load = out_free;
        if (cmd.op != ptt_pkg::OP_TICK) begin
          out_next.kind = ptt_pkg::K_NOTFOUND;
        end else if (pend_valid) begin
          out_next      = pend;
          out_next.last = 1'b1;
        end else begin
          out_next.kind = ptt_pkg::K_NOFIRE;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequence commands over the slots
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      pend_valid <= 1'b0;
      dcnt       <= '0;
      idx        <= '0;
      for (int i = 0; i < ptt_pkg::TIMER_SLOTS; i++) begin
        slot_st[i] <= ptt_pkg::ST_FREE;
      end
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (out_load) begin
        rsp_valid <= 1'b1;
        rsp       <= out_next;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd        <= q_cmd;
            idx        <= '0;
            pend_valid <= 1'b0;
            case (q_cmd.op)
              ptt_pkg::OP_ADD:    state <= S_ADD;
              ptt_pkg::OP_IGNORE: state <= S_RSP;
              default:            state <= S_RD;
            endcase
          end
        end
        S_ADD: begin
          if (out_free) begin
            if (free_found) begin
              slot_st[free_idx] <= ptt_pkg::ST_WORK;
            end
            state <= S_IDLE;
          end
        end
        S_RSP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_RD: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          ent <= e;
          if (cmd.op == ptt_pkg::OP_TICK) begin
            if (slot_st[idx] == ptt_pkg::ST_WORK) begin
              if (e.count < peff_e) begin
                fire  <= (e.count == 32'd0);
                state <= S_UPD;
              end else begin
                rem   <= '0;
                dsh   <= e.count;
                dcnt  <= '0;
                state <= S_DIV;
              end
            end else begin
              // drop a dying entry on this visit
              if (slot_st[idx] == ptt_pkg::ST_DYING) begin
                slot_st[idx] <= ptt_pkg::ST_FREE;
              end
              if (last_slot) begin
                state <= S_END;
              end else begin
                idx   <= idx + 1'b1;
                state <= S_RD;
              end
            end
          end else if (hit) begin
            state <= S_ACT;
          end else if (last_slot) begin
            state <= S_END;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_RD;
          end
        end
        S_DIV: begin
          rem  <= rem_next;
          dsh  <= {dsh[30:0], 1'b0};
          dcnt <= dcnt + 1'b1;
          if (dcnt == 5'd31) begin
            fire  <= (rem_next == 32'd0);
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (upd_ok) begin
            if (fire) begin
              pend_valid <= 1'b1;
              pend       <= '{kind: ptt_pkg::K_FIRED, fired_id: ent.id,
                              fired_in_thread: ent.thread, last: 1'b0};
              if (ent.one_shot) begin
                slot_st[idx] <= ptt_pkg::ST_DYING;
              end
            end
            if (last_slot) begin
              state <= S_END;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_RD;
            end
          end
        end
        S_ACT: begin
          if (out_free) begin
            if (cmd.op == ptt_pkg::OP_PAUSE) begin
              slot_st[idx] <= ptt_pkg::ST_PAUSE;
            end else if (cmd.op == ptt_pkg::OP_CANCEL) begin
              slot_st[idx] <= ptt_pkg::ST_DYING;
            end
            state <= S_IDLE;
          end
        end
        S_END: begin
          if (out_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_pend_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("pending fire left over after a command");

  a_fire_tick: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_next.kind == ptt_pkg::K_FIRED) |-> (cmd.op == ptt_pkg::OP_TICK))
    else $error("fire word outside a tick");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_DIV) |-> (dcnt == 5'd0))
    else $error("remainder counter running outside its phase");

endmodule

>>> hw/rtl/periodic_timer_table.sv
// Periodic timer table with TIMER_SLOTS entries keyed by a nonzero 16-bit id.
// Requests pass a two-word command queue into a sequencer that walks a
// slot RAM with one write and one read port, one slot at a time. Add and
// ignored requests present a single result word once the output is free;
// pause, cancel and period change walk the slots up to the first match (a
// miss walks all slots). A tick walks every slot; a working entry also
// passes an update step, and one whose count has reached its period first
// passes a bit-serial remainder unit that decides whether it fires.
// Fires come out in slot order with last set on the final word; a tick with
// no fire returns one tick-without-fire word.
module periodic_timer_table (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  ptt_pkg::req_word_t  req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output ptt_pkg::rsp_word_t  rsp
);

  logic          q_valid;
  logic          q_pop;
  ptt_pkg::cmd_t q_cmd;

  ptt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  ptt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

>>> tb/timer_table_checker.sv
`timescale 1ns / 1ps

module timer_table_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_stall,
  input  ptt_pkg::req_word_t req,
  input  logic               rsp_valid,
  input  logic               rsp_stall,
  input  ptt_pkg::rsp_word_t rsp,
  output int                 fail_count,
  output int                 pending,
  output int                 fire_total
);
  import ptt_pkg::*;

  // shadow copy of the table
  logic [1:0]  tbl_state  [TIMER_SLOTS];
  logic [15:0] tbl_id     [TIMER_SLOTS];
  logic [31:0] tbl_period [TIMER_SLOTS];
  logic [31:0] tbl_count  [TIMER_SLOTS];
  logic        tbl_once   [TIMER_SLOTS];
  logic        tbl_thread [TIMER_SLOTS];

  rsp_word_t expected_words[$];

  assign pending = expected_words.size();

  function automatic rsp_word_t mk_word(logic [2:0] kind, logic [15:0] id, logic thr,
                                        logic lst);
    rsp_word_t w;
    w.kind = kind;
    w.fired_id = id;
    w.fired_in_thread = thr;
    w.last = lst;
    return w;
  endfunction

  // advance the table by one request and queue the words it answers with
  task automatic apply_request(req_word_t r);
    int slot;
    int nfire;
    logic [31:0] per;
    slot = -1;
    nfire = 0;
    if (r.mode == MODE_TICK) begin
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        if (tbl_state[i] == ST_WORK) begin
          per = (tbl_period[i] == 0) ? 32'd1 : tbl_period[i];
          if (tbl_count[i] % per == 0) begin
            tbl_count[i] = 0;
            expected_words.push_back(mk_word(K_FIRED, tbl_id[i], tbl_thread[i], 1'b0));
            nfire++;
            fire_total++;
            if (tbl_once[i]) tbl_state[i] = ST_DYING;
          end
          tbl_count[i] = tbl_count[i] + 32'd1;
        end else if (tbl_state[i] == ST_DYING) begin
          tbl_state[i] = ST_FREE;
        end
      end
      if (nfire == 0) expected_words.push_back(mk_word(K_NOFIRE, r.timer_id, 1'b0, 1'b1));
      else expected_words[$].last = 1'b1;
    end else if (r.mode > MODE_CHPER || r.timer_id == 0) begin
      expected_words.push_back(mk_word(K_IGNORED, r.timer_id, 1'b0, 1'b1));
    end else if (r.mode == MODE_ADD) begin
      for (int i = TIMER_SLOTS - 1; i >= 0; i--)
        if (tbl_state[i] == ST_FREE) slot = i;
      if (slot < 0) begin
        expected_words.push_back(mk_word(K_FULL, r.timer_id, 1'b0, 1'b1));
      end else begin
        tbl_state[slot] = ST_WORK;
        tbl_id[slot] = r.timer_id;
        tbl_period[slot] = r.period;
        tbl_count[slot] = 0;
        tbl_once[slot] = r.one_shot;
        tbl_thread[slot] = r.run_in_thread;
        expected_words.push_back(mk_word(K_DONE, r.timer_id, 1'b0, 1'b1));
      end
    end else begin
      for (int i = TIMER_SLOTS - 1; i >= 0; i--)
        if (tbl_state[i] != ST_FREE && tbl_id[i] == r.timer_id) slot = i;
      if (slot < 0) begin
        expected_words.push_back(mk_word(K_NOTFOUND, r.timer_id, 1'b0, 1'b1));
      end else begin
        case (r.mode)
          MODE_PAUSE:  tbl_state[slot] = ST_PAUSE;
          MODE_CANCEL: tbl_state[slot] = ST_DYING;
          default:     tbl_period[slot] = r.period;
        endcase
        expected_words.push_back(mk_word(K_DONE, r.timer_id, 1'b0, 1'b1));
      end
    end
  endtask

  // compare one result word against the oldest expectation
  task automatic check_word(rsp_word_t got);
    rsp_word_t want;
    if (expected_words.size() == 0) begin
      $error("unexpected result word: kind %0d id %0h", got.kind, got.fired_id);
      fail_count++;
      return;
    end
    want = expected_words.pop_front();
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, actual %0d", want.kind, got.kind);
      fail_count++;
    end
    if (got.fired_id !== want.fired_id) begin
      $error("fired_id: expected %0h, actual %0h", want.fired_id, got.fired_id);
      fail_count++;
    end
    if (got.fired_in_thread !== want.fired_in_thread) begin
      $error("fired_in_thread: expected %0b, actual %0b", want.fired_in_thread,
             got.fired_in_thread);
      fail_count++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0b, actual %0b", want.last, got.last);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    fire_total = 0;
    for (int i = 0; i < TIMER_SLOTS; i++) tbl_state[i] = ST_FREE;
  end

  // sample both channels at each edge
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) apply_request(req);
      if (rsp_valid && !rsp_stall) check_word(rsp);
    end
  end

  final if (expected_words.size() != 0)
    $display("%0d result words still outstanding", expected_words.size());

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ptt_pkg::*;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  req_word_t req;
  logic      rsp_valid;
  logic      rsp_stall;
  rsp_word_t rsp;
  int        fail_count;
  int        pending;
  int        fire_total;
  int        word_count;
  bit        quiet;
  logic [15:0] id_pool[8];

  periodic_timer_table dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  timer_table_checker checker_i (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .fail_count(fail_count), .pending(pending), .fire_total(fire_total)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // hold a result word back at random, never during the quiet stretch
  always @(posedge clk) begin
    if (rst) rsp_stall <= 1'b0;
    else rsp_stall <= !quiet && ($urandom_range(99) < 11);
  end

  always @(posedge clk)
    if (!rst && rsp_valid && !rsp_stall) word_count++;

  // send one request word and hold it until taken, then maybe idle
  task automatic send_word(logic [2:0] mode, logic [15:0] id, logic [31:0] per,
                           logic once, logic thr);
    req_word_t w;
    w.mode = mode;
    w.timer_id = id;
    w.period = per;
    w.one_shot = once;
    w.run_in_thread = thr;
    req_valid <= 1'b1;
    req <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (!quiet && $urandom_range(99) < 11) begin
      req_valid <= 1'b0;
      req <= req_word_t'($urandom());
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // random request: mostly ids from a small pool so requests find entries
  task automatic send_random();
    int pick;
    logic [31:0] per;
    logic [15:0] id;
    pick = $urandom_range(99);
    id = ($urandom_range(19) == 0) ? 16'd0 :
         ($urandom_range(9) == 0) ? 16'($urandom()) : id_pool[$urandom_range(7)];
    per = ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(0, 5));
    if (pick < 40) send_word(MODE_TICK, 16'($urandom()), $urandom(), 1'($urandom()),
                             1'($urandom()));
    else if (pick < 65) send_word(MODE_ADD, id, per, 1'($urandom()), 1'($urandom()));
    else if (pick < 75) send_word(MODE_PAUSE, id, $urandom(), 1'($urandom()), 1'($urandom()));
    else if (pick < 87) send_word(MODE_CANCEL, id, $urandom(), 1'($urandom()),
                                  1'($urandom()));
    else if (pick < 97) send_word(MODE_CHPER, id, per, 1'($urandom()), 1'($urandom()));
    else send_word(3'($urandom_range(5, 7)), id, $urandom(), 1'($urandom()),
                   1'($urandom()));
  endtask

  initial begin
    #20_000_000;
    $display("timeout with %0d result words outstanding", pending);
    $display("periodic_timer_table: mismatch");
    $finish;
  end

  initial begin
    int waited;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    quiet = 1'b0;
    word_count = 0;
    for (int i = 0; i < 8; i++) id_pool[i] = 16'($urandom_range(1, 65535));
    id_pool[0] = 16'hFFFF;
    id_pool[1] = 16'h0001;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty tick, ignored ids and modes, misses, extremes
    send_word(MODE_TICK, 16'h0000, 32'h0, 1'b0, 1'b0);
    send_word(MODE_ADD, 16'h0000, 32'd1, 1'b0, 1'b0);
    send_word(3'd5, 16'h1234, 32'd1, 1'b0, 1'b0);
    send_word(3'd7, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_word(MODE_PAUSE, 16'hABCD, 32'd0, 1'b0, 1'b0);
    send_word(MODE_ADD, 16'hFFFF, 32'd0, 1'b0, 1'b1);
    send_word(MODE_ADD, 16'h0001, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_word(MODE_ADD, 16'hFFFF, 32'd2, 1'b1, 1'b1);
    send_word(MODE_TICK, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_word(MODE_TICK, 16'h5555, 32'd0, 1'b0, 1'b0);
    send_word(MODE_CHPER, 16'hFFFF, 32'd3, 1'b0, 1'b0);
    send_word(MODE_PAUSE, 16'h0001, 32'd0, 1'b0, 1'b0);
    send_word(MODE_CANCEL, 16'hFFFF, 32'd0, 1'b0, 1'b0);
    send_word(MODE_PAUSE, 16'hFFFF, 32'd0, 1'b0, 1'b0);
    send_word(MODE_TICK, 16'h0000, 32'd0, 1'b0, 1'b0);
    // fill the table, then overflow it
    for (int i = 0; i < TIMER_SLOTS; i++)
      send_word(MODE_ADD, 16'(16'h100 + i), 32'(i), 1'(i), 1'(i >> 1));
    send_word(MODE_ADD, 16'h0BAD, 32'd1, 1'b0, 1'b0);
    send_word(MODE_TICK, 16'h0000, 32'd0, 1'b0, 1'b0);
    send_word(MODE_TICK, 16'h0000, 32'd0, 1'b0, 1'b0);
    for (int i = 0; i < TIMER_SLOTS; i++)
      send_word(MODE_CANCEL, 16'(16'h100 + i), 32'd0, 1'b0, 1'b0);
    send_word(MODE_TICK, 16'h0000, 32'd0, 1'b0, 1'b0);

    // random traffic with a quiet stretch in the middle
    for (int n = 0; n < 400; n++) begin
      quiet = (n >= 150 && n < 230);
      send_random();
    end
    quiet = 1'b0;
    req_valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 200_000) begin
      @(posedge clk);
      waited++;
    end
    repeat (1500) @(posedge clk);

    $display("sent about 450 requests of every mode; %0d result words, %0d fires",
             word_count, fire_total);
    if (fail_count == 0 && pending == 0) begin
      $display("periodic_timer_table: match");
    end else begin
      $display("periodic_timer_table: mismatch");
    end
    $finish;
  end

endmodule

>>> periodic_timer_table.f
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_ram.sv
hw/rtl/ptt_front.sv
hw/rtl/ptt_back.sv
hw/rtl/periodic_timer_table.sv
tb/timer_table_checker.sv
tb/tb_top.sv
